FILE: design/icc_pkg.sv
// Shared types, mode codes and ASCII helpers for the identifier case converter.
`timescale 1ns / 1ps

package icc_pkg;

  localparam int unsigned ModeW = 5;

  // Case styles; codes above SPONGE behave as copy.
  localparam logic [ModeW-1:0] MODE_COPY       = 5'd0;
  localparam logic [ModeW-1:0] MODE_CAMEL      = 5'd1;
  localparam logic [ModeW-1:0] MODE_CAPITAL    = 5'd2;
  localparam logic [ModeW-1:0] MODE_CONSTANT   = 5'd3;
  localparam logic [ModeW-1:0] MODE_DOT        = 5'd4;
  localparam logic [ModeW-1:0] MODE_HEADER     = 5'd5;
  localparam logic [ModeW-1:0] MODE_NO         = 5'd6;
  localparam logic [ModeW-1:0] MODE_PARAM      = 5'd7;
  localparam logic [ModeW-1:0] MODE_PASCAL     = 5'd8;
  localparam logic [ModeW-1:0] MODE_PATH       = 5'd9;
  localparam logic [ModeW-1:0] MODE_SENTENCE   = 5'd10;
  localparam logic [ModeW-1:0] MODE_SNAKE      = 5'd11;
  localparam logic [ModeW-1:0] MODE_TITLE      = 5'd12;
  localparam logic [ModeW-1:0] MODE_SWAP       = 5'd13;
  localparam logic [ModeW-1:0] MODE_LOWER      = 5'd14;
  localparam logic [ModeW-1:0] MODE_LOWERFIRST = 5'd15;
  localparam logic [ModeW-1:0] MODE_UPPER      = 5'd16;
  localparam logic [ModeW-1:0] MODE_UPPERFIRST = 5'd17;
  localparam logic [ModeW-1:0] MODE_SPONGE     = 5'd18;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // One source item as it sits in the input register.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       last_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       string_end;
  } res_t;

  function automatic logic is_up(input logic [7:0] b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_lo(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] b);
    return is_lo(b) ? (b - CASE_BIT) : b;
  endfunction

  function automatic logic [7:0] to_lo(input logic [7:0] b);
    return is_up(b) ? (b + CASE_BIT) : b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return is_blank(b) || (b == CH_DOT) || (b == CH_UNDER) ||
           (b == CH_SLASH) || (b == CH_DASH);
  endfunction

endpackage

FILE: design/icc_step.sv
// Per-string state and the combinational rewrite of one source item into results.
`timescale 1ns / 1ps

module icc_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [icc_pkg::ModeW-1:0]     case_mode,
  input  logic                          take,
  input  icc_pkg::item_t                item,
  output logic [1:0]                    res_cnt,
  output icc_pkg::res_t                 res0,
  output icc_pkg::res_t                 res1
);

  logic prev_lower, sep_pending, past_leading_blanks;
  logic first_output, prev_out_separator, index_parity;
  logic prev_lower_next, sep_pending_next, past_leading_blanks_next;
  logic first_output_next, prev_out_separator_next, index_parity_next;

  logic       word_mode;
  logic       fo, pos, start;
  logic [7:0] b, lc, cb, sb, rb;

  assign b         = item.in_byte;
  assign lc        = icc_pkg::to_lo(b);
  assign word_mode = (case_mode >= icc_pkg::MODE_CAMEL) &&
                     (case_mode <= icc_pkg::MODE_TITLE);

  // Separator byte of the word styles.
  always_comb begin
    case (case_mode)
      icc_pkg::MODE_CONSTANT, icc_pkg::MODE_SNAKE: sb = icc_pkg::CH_UNDER;
      icc_pkg::MODE_DOT:                           sb = icc_pkg::CH_DOT;
      icc_pkg::MODE_HEADER, icc_pkg::MODE_PARAM:   sb = icc_pkg::CH_DASH;
      icc_pkg::MODE_PATH:                          sb = icc_pkg::CH_SLASH;
      default:                                     sb = icc_pkg::CH_SPACE;
    endcase
  end

  // Byte-wise raw styles.
  always_comb begin
    case (case_mode)
      icc_pkg::MODE_SWAP:       rb = icc_pkg::is_up(b) ? lc : icc_pkg::to_up(b);
      icc_pkg::MODE_LOWER:      rb = lc;
      icc_pkg::MODE_LOWERFIRST: rb = first_output ? lc : b;
      icc_pkg::MODE_UPPER:      rb = icc_pkg::to_up(b);
      icc_pkg::MODE_UPPERFIRST: rb = first_output ? icc_pkg::to_up(b) : b;
      icc_pkg::MODE_SPONGE:     rb = index_parity ? lc : icc_pkg::to_up(b);
      default:                  rb = b;
    endcase
  end

  always_comb begin
    res_cnt                  = 2'd0;
    res0                     = '0;
    res1                     = '0;
    prev_lower_next          = prev_lower;
    sep_pending_next         = sep_pending;
    past_leading_blanks_next = past_leading_blanks;
    index_parity_next        = index_parity;
    fo                       = first_output;
    pos                      = prev_out_separator;
    start                    = 1'b0;
    cb                       = lc;

    if (item.has_byte) begin
      if (word_mode) begin
        if (past_leading_blanks || !icc_pkg::is_blank(b)) begin
          past_leading_blanks_next = 1'b1;
          if (icc_pkg::is_sep(b)) begin
            sep_pending_next = 1'b1;
          end else begin
            // Word break: pending separator or lower-to-upper change.
            if (sep_pending || (prev_lower && icc_pkg::is_up(b))) begin
              if (!(((case_mode == icc_pkg::MODE_CAMEL) ||
                     (case_mode == icc_pkg::MODE_PASCAL)) && !fo)) begin
                res0    = '{out_byte: sb, out_valid: 1'b1, string_end: 1'b0};
                res_cnt = 2'd1;
              end
              fo  = 1'b0;
              pos = 1'b1;
            end
            sep_pending_next = 1'b0;
            start = fo || pos;
            case (case_mode)
              icc_pkg::MODE_CAPITAL, icc_pkg::MODE_TITLE,
              icc_pkg::MODE_HEADER, icc_pkg::MODE_PASCAL: begin
                cb = start ? icc_pkg::to_up(lc) : lc;
              end
              icc_pkg::MODE_CONSTANT: cb = icc_pkg::to_up(lc);
              icc_pkg::MODE_CAMEL:    cb = (!fo && pos) ? icc_pkg::to_up(lc) : lc;
              icc_pkg::MODE_SENTENCE: cb = fo ? icc_pkg::to_up(lc) : lc;
              default:                cb = lc;
            endcase
            if (res_cnt == 2'd0) begin
              res0 = '{out_byte: cb, out_valid: 1'b1, string_end: 1'b0};
            end else begin
              res1 = '{out_byte: cb, out_valid: 1'b1, string_end: 1'b0};
            end
            res_cnt = res_cnt + 2'd1;
            fo      = 1'b0;
            pos     = 1'b0;
          end
        end
      end else begin
        res0    = '{out_byte: rb, out_valid: 1'b1, string_end: 1'b0};
        res_cnt = 2'd1;
        fo      = 1'b0;
      end
      prev_lower_next   = icc_pkg::is_lo(b);
      index_parity_next = !index_parity;
    end

    first_output_next       = fo;
    prev_out_separator_next = pos;

    // End of string: mark the last result, or send a bare end mark.
    if (!item.has_byte || item.last_byte) begin
      case (res_cnt)
        2'd0: begin
          res0    = '{out_byte: 8'h00, out_valid: 1'b0, string_end: 1'b1};
          res_cnt = 2'd1;
        end
        2'd1:    res0.string_end = 1'b1;
        default: res1.string_end = 1'b1;
      endcase
      prev_lower_next          = 1'b0;
      sep_pending_next         = 1'b0;
      past_leading_blanks_next = 1'b0;
      first_output_next        = 1'b1;
      prev_out_separator_next  = 1'b0;
      index_parity_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lower          <= 1'b0;
      sep_pending         <= 1'b0;
      past_leading_blanks <= 1'b0;
      first_output        <= 1'b1;
      prev_out_separator  <= 1'b0;
      index_parity        <= 1'b0;
    end else if (take) begin
      prev_lower          <= prev_lower_next;
      sep_pending         <= sep_pending_next;
      past_leading_blanks <= past_leading_blanks_next;
      first_output        <= first_output_next;
      prev_out_separator  <= prev_out_separator_next;
      index_parity        <= index_parity_next;
    end
  end

  // A string end always produces at least one result.
  a_end_has_result: assert property (@(posedge clk) disable iff (rst)
    (take && (!item.has_byte || item.last_byte)) |-> (res_cnt != 2'd0))
    else $error("string end produced no result");

  // After a string end the per-string state is back to its start.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && (!item.has_byte || item.last_byte)) |=>
      (first_output && !sep_pending && !past_leading_blanks && !index_parity))
    else $error("string state not cleared at end");

  // Two results only ever come from a word style: a separator followed by a word byte.
  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    (res_cnt == 2'd2) |-> (word_mode && res0.out_valid && res1.out_valid &&
                           !res0.string_end))
    else $error("malformed result pair");

endmodule

FILE: design/icc_outq.sv
// Two-entry result buffer that takes up to two results per cycle as room allows and sends one while res_ready is high.
`timescale 1ns / 1ps

module icc_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [1:0]     push_cnt,
  input  icc_pkg::res_t  push0,
  input  icc_pkg::res_t  push1,
  output logic           room,
  output logic           res_valid,
  input  logic           res_ready,
  output icc_pkg::res_t  head
);

  icc_pkg::res_t q0, q1, q0_next, q1_next;
  logic [1:0]    cnt, cnt_next, kept, free;
  logic          pop;
  icc_pkg::res_t sh0;

  assign pop       = (cnt != 2'd0) && res_ready;
  assign free      = 2'd2 - cnt + {1'b0, pop};
  assign room      = (push_cnt <= free);
  assign kept      = cnt - {1'b0, pop};
  assign sh0       = pop ? q1 : q0;
  assign res_valid = (cnt != 2'd0);
  assign head      = q0;

  always_comb begin
    q0_next  = (kept != 2'd0) ? sh0 : push0;
    case (kept)
      2'd0:    q1_next = push1;
      2'd1:    q1_next = push0;
      default: q1_next = q1;
    endcase
    cnt_next = kept + (push ? push_cnt : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_cnt <= free))
    else $error("result buffer overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result buffer count out of range");

endmodule

FILE: design/identifier_case_converter.sv
// Top level of the streaming identifier case converter.
`timescale 1ns / 1ps

// Identifier case converter: feed a string one byte per transfer on the input
// channel (in_byte, has_byte, last_byte) and collect the rewritten string on
// the result channel (out_byte, out_valid, string_end). case_mode selects one
// of 19 styles (copy, camel, capital, constant, dot, header, no, param,
// pascal, path, sentence, snake, title, swap, lower, lowerfirst, upper,
// upperfirst, sponge); codes 19..31 act as copy. Write case_mode through
// cfg_wr_en / cfg_wr_data only between strings while the block is drained.
// Each source item waits in the input register, where short combinational
// rewrite logic turns it into results that land in a two-entry buffer when
// the buffer has room; a result is offered from that buffer, so one byte per
// cycle streams through while the buffer has room and res_ready is high. An
// item that yields a separator plus a word byte needs two result slots;
// items that yield nothing (dropped blanks, separator runs) still pass through
// the input register. A string ends on last_byte, or on an item with has_byte
// low, which produces a bare end mark when no byte is left to carry string_end.
module identifier_case_converter (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [icc_pkg::ModeW-1:0] cfg_wr_data,
  // source items
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      has_byte,
  input  logic                      last_byte,
  // result items
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [7:0]                out_byte,
  output logic                      out_valid,
  output logic                      string_end
);

  logic [icc_pkg::ModeW-1:0] case_mode;
  logic                      a_valid;
  icc_pkg::item_t            a_item;
  logic                      adv;
  logic                      room;
  logic [1:0]                res_cnt;
  icc_pkg::res_t             res0, res1, head;

  // Hold the style register; the user must write it only while drained, the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      case_mode <= icc_pkg::MODE_COPY;
    end else if (cfg_wr_en) begin
      case_mode <= cfg_wr_data;
    end
  end

  // Input register: advance its item into the result buffer when the buffer
  // has room for every result it produces; refill in the same cycle.
  assign adv      = a_valid && room;
  assign in_ready = !a_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_item <= '{in_byte: in_byte, has_byte: has_byte, last_byte: last_byte};
    end
  end

  icc_step u_step (
    .clk       (clk),
    .rst       (rst),
    .case_mode (case_mode),
    .take      (adv),
    .item      (a_item),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  icc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (adv),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .head      (head)
  );

  assign out_byte   = head.out_byte;
  assign out_valid  = head.out_valid;
  assign string_end = head.string_end;

  // A held input item only leaves the register by advancing.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !adv) |=> (a_valid && $stable(a_item)))
    else $error("input register lost an item");

  // Nothing advances from an empty input register.
  a_adv_needs_item: assert property (@(posedge clk) disable iff (rst)
    adv |-> a_valid)
    else $error("advance without an item");

endmodule
